// ===== rtl/core/signed_decimal_glyph_writer_defines.svh =====
// Assertion macros used by the glyph writer queue.
`ifndef SIGNED_DECIMAL_GLYPH_WRITER_DEFINES_SVH
`define SIGNED_DECIMAL_GLYPH_WRITER_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define SDGW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sdgw: assertion failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define SDGW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sdgw: assertion failed");

`endif

// ===== rtl/core/sdgw_pkg.sv =====
package sdgw_pkg;

    localparam int GLYPH_WIDTH = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0]  START_RESET   = 7'd30;
    localparam logic [7:0]  COL_MAX       = 8'd101;
    localparam logic [7:0]  PAGE_BASE     = 8'hB0;
    localparam logic [4:0]  COL_HIGH_BASE = 5'h10;
    localparam logic [7:0]  COL_STEP      = 8'(GLYPH_WIDTH);

    // floor(x / 10) == (x * 52429) >> 19 for every 16-bit x
    localparam logic [15:0] DIV10_MULT  = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    // Glyph codes: 0..9 are digits
    localparam logic [3:0] GLYPH_PLUS  = 4'd10;
    localparam logic [3:0] GLYPH_MINUS = 4'd11;

    typedef struct packed {
        logic [3:0] code;
        logic [7:0] col;   // unclamped column
        logic       last;
    } t_glyph_cmd;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIGIT,
        F_SIGN
    } t_front_state;

    function automatic logic [47:0] glyph_rom(input logic [3:0] code, input logic page);
        logic [47:0] p0;
        logic [47:0] p1;
        unique case (code)
            4'd0: begin p0 = 48'h7FC1C17F0000; p1 = 48'h008080000000; end
            4'd1: begin p0 = 48'hFFFF06040000; p1 = 48'h808000000000; end
            4'd2: begin p0 = 48'hCFDDF9F30000; p1 = 48'h008080000000; end
            4'd3: begin p0 = 48'h77DDC9630000; p1 = 48'h008080000000; end
            4'd4: begin p0 = 48'hFF08080F0000; p1 = 48'h800000800000; end
            4'd5: begin p0 = 48'hF9C9C9CF0000; p1 = 48'h808080800000; end
            4'd6: begin p0 = 48'h73C9C97F0000; p1 = 48'h008080000000; end
            4'd7: begin p0 = 48'h030C30C00000; p1 = 48'h808080800000; end
            4'd8: begin p0 = 48'h77C9C9770000; p1 = 48'h008080000000; end
            4'd9: begin p0 = 48'h7FC9C9670000; p1 = 48'h008080000000; end
            GLYPH_PLUS: begin p0 = 48'h187E7E180000; p1 = 48'h0; end
            GLYPH_MINUS: begin p0 = 48'h181818180000; p1 = 48'h0; end
            default: begin p0 = 48'h0; p1 = 48'h0; end
        endcase
        return page ? p1 : p0;
    endfunction

endpackage

// ===== rtl/core/signed_decimal_glyph_writer.sv =====
// Signed decimal glyph writer.
// Slave stream: one beat carries a 16-bit two's complement number in tdata.
// Master stream: page-addressed glyph writes for an LCD, two beats per glyph
// (page 0 then page 1). Digits go out least significant first at columns
// start_column + 6*j, capped at 101, then a +/- glyph; tlast marks its page 1.
// Config channel: a write sets start_column (7 bits, 30 after reset).
// A number of n decimal digits yields 2*(n+1) beats, 4 to 12.
// The first beat of a number passes the front state, the queue, the back end's
// glyph register and the output register before tvalid rises.
// The back end sends one beat per cycle while the queue holds glyphs and the
// master side does not stall. The front end splits one digit per cycle while
// the queue is not full, with a multiply by the reciprocal of ten, takes a new
// number only once the sign of the last one is queued, and runs ahead of the
// back end through a four-entry queue.
// Reset clears the front state, the queue and the output register; no beat is
// pending afterward. A stall on the master side holds the output register, fills
// the queue and then holds tready low on the slave side; nothing is dropped.
module signed_decimal_glyph_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] page_command, [11:8] column_low_command, [16:12] column_high_command,
    // [64:17] glyph_bytes, [71:65] zero
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tlast,   // last_write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data      // start_column
);

    logic [6:0] r_start_column;

    sdgw_pkg::t_glyph_cmd push_data;
    sdgw_pkg::t_glyph_cmd pop_data;
    logic push;
    logic pop;
    logic full;
    logic empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_column <= sdgw_pkg::START_RESET;
        end else if (i_cfg_valid) begin
            r_start_column <= i_cfg_data;
        end
    end

    sdgw_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_value        (s_axis_tdata),
        .i_start_column (r_start_column),
        .i_full         (full),
        .o_push         (push),
        .o_push_data    (push_data)
    );

    sdgw_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_full      (full),
        .o_empty     (empty)
    );

    sdgw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (pop_data),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

// ===== rtl/core/sdgw_front.sv =====
module sdgw_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [15:0]         i_value,
    input  logic [6:0]          i_start_column,
    input  logic                i_full,
    output logic                o_push,
    output sdgw_pkg::t_glyph_cmd o_push_data
);

    sdgw_pkg::t_front_state r_state, n_state;
    logic [15:0] r_mag, n_mag;
    logic [7:0]  r_col, n_col;
    logic        r_neg, n_neg;

    logic [31:0] prod;
    logic [15:0] quot;
    logic [15:0] rem_full;
    logic [3:0]  rem;
    logic        accept;

    // Peel one decimal digit off the magnitude per cycle while the queue has room
    assign prod     = {16'd0, r_mag} * {16'd0, sdgw_pkg::DIV10_MULT};
    assign quot     = 16'(prod >> sdgw_pkg::DIV10_SHIFT);
    assign rem_full = r_mag - ((quot << 3) + (quot << 1));
    assign rem      = rem_full[3:0];
    assign accept   = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sdgw_pkg::F_IDLE: begin
                if (i_valid) n_state = sdgw_pkg::F_DIGIT;
            end
            sdgw_pkg::F_DIGIT: begin
                if (!i_full && quot == 16'd0) n_state = sdgw_pkg::F_SIGN;
            end
            sdgw_pkg::F_SIGN: begin
                if (!i_full) n_state = sdgw_pkg::F_IDLE;
            end
            default: n_state = sdgw_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_ready     = 1'b0;
        o_push      = 1'b0;
        o_push_data = '{code: rem, col: r_col, last: 1'b0};
        n_mag       = r_mag;
        n_col       = r_col;
        n_neg       = r_neg;
        unique case (r_state)
            sdgw_pkg::F_IDLE: begin
                o_ready = 1'b1;
                if (accept) begin
                    n_neg = i_value[15];
                    n_mag = i_value[15] ? 16'(-i_value) : i_value;
                    n_col = {1'b0, i_start_column};
                end
            end
            sdgw_pkg::F_DIGIT: begin
                if (!i_full) begin
                    o_push = 1'b1;
                    n_mag  = quot;
                    n_col  = r_col + sdgw_pkg::COL_STEP;
                end
            end
            sdgw_pkg::F_SIGN: begin
                o_push = !i_full;
                o_push_data = '{code: r_neg ? sdgw_pkg::GLYPH_MINUS : sdgw_pkg::GLYPH_PLUS,
                                col: r_col, last: 1'b1};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdgw_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_mag <= n_mag;
        r_col <= n_col;
        r_neg <= n_neg;
    end

endmodule

// ===== rtl/core/sdgw_queue.sv =====
`include "signed_decimal_glyph_writer_defines.svh"

module sdgw_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sdgw_pkg::t_glyph_cmd i_push_data,
    input  logic                 i_pop,
    output sdgw_pkg::t_glyph_cmd o_pop_data,
    output logic                 o_full,
    output logic                 o_empty
);

    sdgw_pkg::t_glyph_cmd r_mem [sdgw_pkg::QUEUE_DEPTH];
    logic [sdgw_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [sdgw_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [sdgw_pkg::QUEUE_CW-1:0] r_count;

    assign o_full     = r_count == sdgw_pkg::QUEUE_CW'(sdgw_pkg::QUEUE_DEPTH);
    assign o_empty    = r_count == '0;
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_push_data;
    end

    `SDGW_ASSERT_IMP(a_no_push_full, i_push, !o_full)
    `SDGW_ASSERT_IMP(a_no_pop_empty, i_pop, !o_empty)
    `SDGW_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

// ===== rtl/core/sdgw_back.sv =====
module sdgw_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  sdgw_pkg::t_glyph_cmd i_cmd,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [71:0]          o_data,
    output logic                 o_last
);

    sdgw_pkg::t_glyph_cmd r_cur;
    logic        r_have;
    logic        r_page;
    logic        r_out_valid;
    logic [71:0] r_out_data;
    logic        r_out_last;

    logic        load;
    logic [7:0]  col_clamped;
    logic [7:0]  page_cmd;
    logic [3:0]  col_low;
    logic [4:0]  col_high;
    logic [71:0] beat;

    assign load  = r_have && (!r_out_valid || i_ready);
    assign o_pop = !i_empty && (!r_have || (load && r_page));

    always_comb begin
        col_clamped = (r_cur.col > sdgw_pkg::COL_MAX) ? sdgw_pkg::COL_MAX : r_cur.col;
        page_cmd    = sdgw_pkg::PAGE_BASE + 8'd7 - {7'd0, r_page};
        col_low     = col_clamped[3:0];
        col_high    = sdgw_pkg::COL_HIGH_BASE + {1'b0, col_clamped[7:4]};
        beat        = {7'd0, sdgw_pkg::glyph_rom(r_cur.code, r_page), col_high, col_low,
                       page_cmd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_page      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // page 1 finishes the glyph; take the next one in the same cycle
            if (o_pop) begin
                r_have <= 1'b1;
                r_page <= 1'b0;
            end else if (load && r_page) begin
                r_have <= 1'b0;
                r_page <= 1'b0;
            end else if (load) begin
                r_page <= 1'b1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_pop) r_cur <= i_cmd;
        if (load) begin
            r_out_data <= beat;
            r_out_last <= r_cur.last && r_page;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS = 100;

    localparam logic [47:0] DIGIT_PAGE0 [10] = '{
        48'h7FC1C17F0000, 48'hFFFF06040000, 48'hCFDDF9F30000, 48'h77DDC9630000,
        48'hFF08080F0000, 48'hF9C9C9CF0000, 48'h73C9C97F0000, 48'h030C30C00000,
        48'h77C9C9770000, 48'h7FC9C9670000
    };
    localparam logic [47:0] DIGIT_PAGE1 [10] = '{
        48'h008080000000, 48'h808000000000, 48'h008080000000, 48'h008080000000,
        48'h800000800000, 48'h808080800000, 48'h008080000000, 48'h808080800000,
        48'h008080000000, 48'h008080000000
    };
    localparam logic [47:0] PLUS_PAGE0  = 48'h187E7E180000;
    localparam logic [47:0] MINUS_PAGE0 = 48'h181818180000;

    localparam int EDGE_VALUES [20] = '{
        0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 9999, 10000, 32767, -32768, -32767,
        12345, 6789, -5678, 21845, -21846
    };

    // Idle mix per traffic phase: none, sender only, receiver only, both
    localparam int SENDER_IDLE [4] = '{0, 48, 0, 38};
    localparam int RECV_STALL  [4] = '{0, 0, 48, 38};

    typedef struct {
        logic [7:0]  page_cmd;
        logic [3:0]  col_lo;
        logic [4:0]  col_hi;
        logic [47:0] glyph;
        logic        last;
    } t_glyph_write;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // [15:0] value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] page_command, [11:8] column_low_command, [16:12] column_high_command,
    // [64:17] glyph_bytes, [71:65] zero
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;          // last_write
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data = '0;       // start_column

    t_glyph_write pending_writes [$];
    logic [6:0]   start_column = sdgw_pkg::START_RESET;
    int           sender_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           mismatches = 0;
    int           quiet_cycles = 0;

    signed_decimal_glyph_writer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Digits least significant first, then the sign; two pages per glyph.
    function automatic void queue_glyph_writes(input logic [15:0] raw);
        logic [16:0]  mag;
        int           ndig;
        int           rest;
        int           digit;
        logic [7:0]   col;
        logic [47:0]  top;
        logic [47:0]  bot;
        t_glyph_write w;
        mag = raw[15] ? 17'h10000 - {1'b0, raw} : {1'b0, raw};
        ndig = 1;
        rest = int'(mag);
        while (rest >= 10) begin
            rest = rest / 10;
            ndig++;
        end
        rest = int'(mag);
        for (int j = 0; j <= ndig; j++) begin
            if (j < ndig) begin
                digit = rest % 10;
                rest = rest / 10;
                top = DIGIT_PAGE0[digit];
                bot = DIGIT_PAGE1[digit];
            end else begin
                top = raw[15] ? MINUS_PAGE0 : PLUS_PAGE0;
                bot = '0;
            end
            col = 8'(start_column) + 8'(sdgw_pkg::GLYPH_WIDTH * j);
            if (col > sdgw_pkg::COL_MAX)
                col = sdgw_pkg::COL_MAX;
            for (int p = 0; p < 2; p++) begin
                w.page_cmd = sdgw_pkg::PAGE_BASE + 8'd7 - 8'(p);
                w.col_lo = col[3:0];
                w.col_hi = sdgw_pkg::COL_HIGH_BASE + 5'(col[7:4]);
                w.glyph = (p == 0) ? top : bot;
                w.last = (j == ndig) && (p == 1);
                pending_writes.push_back(w);
            end
        end
    endfunction

    function automatic logic [15:0] random_value();
        int pow10 [6];
        int len;
        int mag;
        pow10 = '{1, 10, 100, 1000, 10000, 100000};
        if ($urandom_range(5) == 0)
            return 16'($urandom);
        len = $urandom_range(5, 1);
        mag = $urandom_range(pow10[len] - 1, (len == 1) ? 0 : pow10[len - 1]);
        if (mag > 32768)
            mag = $urandom_range(32768, 10000);
        if (mag == 32768 || (mag != 0 && $urandom_range(1) == 1))
            return 16'(-mag);
        return 16'(mag);
    endfunction

    // Call right after a falling edge; returns right after a falling edge.
    task automatic send_value(input logic [15:0] v);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= v;
        do @(posedge i_clk); while (!s_axis_tready);
        queue_glyph_writes(v);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_writes.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_start_column(input logic [6:0] c);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= c;
        do @(posedge i_clk); while (!o_cfg_ready);
        start_column = c;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_value_extremes();
        foreach (EDGE_VALUES[k])
            send_value(16'(EDGE_VALUES[k]));
    endtask

    // Left edge, right edge, above the clamp limit, and glyphs running past the edge
    task automatic test_column_extremes();
        logic [6:0] cols [4];
        cols = '{7'd0, 7'd101, 7'd127, 7'd90};
        foreach (cols[k]) begin
            write_start_column(cols[k]);
            send_value(16'h8000);
            send_value(16'd7);
        end
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 4; ph++) begin
            write_start_column((ph == 0) ? 7'(sdgw_pkg::START_RESET)
                                         : 7'($urandom_range(127)));
            sender_idle_pct = SENDER_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            repeat (PHASE_ITEMS)
                send_value(random_value());
        end
    endtask

    always @(negedge i_clk)
        m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : check_writes
        t_glyph_write w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_writes.size() == 0) begin
                $error("unexpected glyph write beat: 0x%0h", m_axis_tdata);
                mismatches++;
            end else begin
                w = pending_writes.pop_front();
                check_field("page_command", w.page_cmd, m_axis_tdata[7:0]);
                check_field("column_low_command", w.col_lo, m_axis_tdata[11:8]);
                check_field("column_high_command", w.col_hi, m_axis_tdata[16:12]);
                check_field("glyph_bytes", w.glyph, m_axis_tdata[64:17]);
                check_field("tdata_pad", 0, m_axis_tdata[71:65]);
                check_field("last_write", w.last, m_axis_tlast);
            end
        end
    end

    // Count cycles where no channel moves a beat
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_value_extremes();
        test_column_extremes();
        test_random_traffic();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_writes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sdgw_pkg.sv
rtl/core/sdgw_front.sv
rtl/core/sdgw_queue.sv
rtl/core/sdgw_back.sv
rtl/core/signed_decimal_glyph_writer.sv
tb/sv/tb.sv
